>>> src/assert_macros.svh
// Assertion macros shared by the serial master RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Consequence checked in the clock cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> src/rtcsm_pkg.sv
// Types and constants for the three-wire RTC serial master.
`timescale 1ns / 1ps

package rtcsm_pkg;

  // Request codes; idle doubles as the "tick only" request
  typedef enum logic [2:0] {
    OP_IDLE         = 3'd0,
    OP_SINGLE_READ  = 3'd1,
    OP_SINGLE_WRITE = 3'd2,
    OP_BURST_READ   = 3'd3,
    OP_BURST_WRITE  = 3'd4
  } op_kind_t;

  // Tick within one serial bit
  typedef enum logic [1:0] {
    PH_SETUP = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2
  } phase_t;

  localparam int BURST_BYTES = 8;
  localparam int CMD_BITS    = 8;

  localparam logic [7:0] CMD_WRITE_BASE  = 8'h80;
  localparam logic [7:0] CMD_READ_BASE   = 8'h81;
  localparam logic [7:0] CMD_BURST_WRITE = 8'hBE;
  localparam logic [7:0] CMD_BURST_READ  = 8'hBF;

  localparam logic [6:0] SINGLE_LAST_BIT = 7'(2 * CMD_BITS - 1);
  localparam logic [6:0] BURST_LAST_BIT  = 7'(CMD_BITS + 8 * BURST_BYTES - 1);

  typedef struct packed {
    logic [2:0]  req_type;
    logic [5:0]  reg_addr;
    logic [63:0] write_data;
    logic        io_in;
  } rtcsm_in_t;

  typedef struct packed {
    logic        chip_enable;
    logic        serial_clock;
    logic        io_out;
    logic        io_drive;
    logic        busy_res;
    logic        done_res;
    logic [63:0] read_data;
    logic        rejected;
  } rtcsm_out_t;

endpackage

>>> src/rtcsm_core.sv
// Bit sequencer: transaction state and per-tick pin levels.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtcsm_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  rtcsm_pkg::rtcsm_in_t  in_item,
  output rtcsm_pkg::rtcsm_out_t res
);
  import rtcsm_pkg::*;

  op_kind_t    op_r, op_r_nxt;
  logic [1:0]  phase_r, phase_r_nxt;
  logic [6:0]  idx_r, idx_r_nxt;
  logic [7:0]  cmd_r, cmd_r_nxt;
  logic [63:0] wsh_r, wsh_r_nxt;
  logic [63:0] rsh_r, rsh_r_nxt;
  logic        en_r, en_r_nxt;

  logic        is_req, start, active, phase_low, is_read, is_burst, reading, ending;
  op_kind_t    eff_op;
  logic [1:0]  eff_phase;
  logic [6:0]  eff_idx, idx_m8, last_bit;
  logic [5:0]  data_pos;
  logic [7:0]  eff_cmd;
  logic [63:0] eff_wsh, eff_rsh, rsh_upd;
  logic        tx_bit;

  // Request decode and the state seen by this tick
  always_comb begin
    is_req = (in_item.req_type == OP_SINGLE_READ) || (in_item.req_type == OP_SINGLE_WRITE) ||
             (in_item.req_type == OP_BURST_READ) || (in_item.req_type == OP_BURST_WRITE);
    start  = (op_r == OP_IDLE) && is_req;
    if (start) begin
      eff_op    = op_kind_t'(in_item.req_type);
      eff_phase = PH_SETUP;
      eff_idx   = '0;
      eff_rsh   = '0;
    end else begin
      eff_op    = op_r;
      eff_phase = phase_r;
      eff_idx   = idx_r;
      eff_rsh   = rsh_r;
    end
    eff_cmd = cmd_r;
    eff_wsh = wsh_r;
    if (start) begin
      unique case (op_kind_t'(in_item.req_type))
        OP_SINGLE_READ: begin
          eff_cmd = {1'b0, in_item.reg_addr, 1'b0} | CMD_READ_BASE;
          eff_wsh = '0;
        end
        OP_SINGLE_WRITE: begin
          eff_cmd = {1'b0, in_item.reg_addr, 1'b0} | CMD_WRITE_BASE;
          eff_wsh = {56'd0, in_item.write_data[7:0]};
        end
        OP_BURST_READ: begin
          eff_cmd = CMD_BURST_READ;
          eff_wsh = '0;
        end
        OP_BURST_WRITE: begin
          eff_cmd = CMD_BURST_WRITE;
          eff_wsh = in_item.write_data;
        end
        default: begin
          eff_cmd = cmd_r;
          eff_wsh = wsh_r;
        end
      endcase
    end
  end

  // Bit position, direction and the end-of-transaction test
  always_comb begin
    active    = (eff_op != OP_IDLE);
    // an unused phase code behaves like the clock-low phase
    phase_low = (eff_phase != PH_SETUP) && (eff_phase != PH_HIGH);
    is_read   = (eff_op == OP_SINGLE_READ) || (eff_op == OP_BURST_READ);
    is_burst  = (eff_op == OP_BURST_READ) || (eff_op == OP_BURST_WRITE);
    idx_m8    = eff_idx - 7'(CMD_BITS);
    data_pos  = idx_m8[5:0];
    reading   = is_read && (eff_idx >= 7'(CMD_BITS));
    last_bit  = is_burst ? BURST_LAST_BIT : SINGLE_LAST_BIT;
    ending    = active && phase_low && (eff_idx >= last_bit);
    rsh_upd   = (reading && (eff_phase == PH_SETUP)) ?
                (eff_rsh | (64'(in_item.io_in) << data_pos)) : eff_rsh;
    tx_bit    = (eff_idx < 7'(CMD_BITS)) ? eff_cmd[eff_idx[2:0]] : eff_wsh[data_pos];
  end

  // Next state
  always_comb begin
    op_r_nxt    = op_r;
    phase_r_nxt = phase_r;
    idx_r_nxt   = idx_r;
    cmd_r_nxt   = cmd_r;
    wsh_r_nxt   = wsh_r;
    rsh_r_nxt   = rsh_r;
    en_r_nxt    = en_r;
    if (active) begin
      op_r_nxt  = eff_op;
      cmd_r_nxt = eff_cmd;
      wsh_r_nxt = eff_wsh;
      rsh_r_nxt = rsh_upd;
      en_r_nxt  = 1'b1;
      if (ending) begin
        op_r_nxt    = OP_IDLE;
        phase_r_nxt = PH_SETUP;
        idx_r_nxt   = '0;
        en_r_nxt    = 1'b0;
      end else if (phase_low) begin
        phase_r_nxt = PH_SETUP;
        idx_r_nxt   = eff_idx + 7'd1;
      end else begin
        phase_r_nxt = eff_phase + 2'd1;
      end
    end
  end

  // Pin levels and status for this tick
  always_comb begin
    res.chip_enable  = en_r_nxt;
    res.serial_clock = active && !ending && (eff_phase == PH_HIGH);
    res.io_drive     = active && !ending && !reading;
    res.io_out       = res.io_drive ? tx_bit : 1'b1;
    res.busy_res     = active && !ending;
    res.done_res     = ending;
    res.read_data    = (ending && is_read) ? rsh_upd : 64'd0;
    res.rejected     = (op_r != OP_IDLE) && is_req;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r    <= OP_IDLE;
      phase_r <= PH_SETUP;
      idx_r   <= '0;
      en_r    <= 1'b0;
    end else if (step_en) begin
      op_r    <= op_r_nxt;
      phase_r <= phase_r_nxt;
      idx_r   <= idx_r_nxt;
      en_r    <= en_r_nxt;
    end
  end

  // Shift data; only read while a transaction runs
  always_ff @(posedge clk) begin
    if (step_en) begin
      cmd_r <= cmd_r_nxt;
      wsh_r <= wsh_r_nxt;
      rsh_r <= rsh_r_nxt;
    end
  end

  `ASSERT_IMPL(a_busy_has_ce, clk, rst_n, res.busy_res, res.chip_enable)
  `ASSERT_IMPL(a_done_releases, clk, rst_n, res.done_res,
               !res.chip_enable && !res.io_drive && !res.busy_res && !res.serial_clock)
  `ASSERT_IMPL(a_enable_tracks_op, clk, rst_n, 1'b1, en_r == (op_r != OP_IDLE))
  `ASSERT_IMPL(a_index_bound, clk, rst_n, op_r != OP_IDLE, idx_r <= BURST_LAST_BIT)
  `ASSERT_NEXT(a_done_goes_idle, clk, rst_n, step_en && res.done_res, op_r == OP_IDLE)

endmodule

>>> src/rtcsm_outbuf.sv
// Result register with a skid stage for the output channel.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtcsm_outbuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  rtcsm_pkg::rtcsm_out_t in_res,
  output logic                  in_stall,
  output logic                  out_valid,
  output rtcsm_pkg::rtcsm_out_t out_res,
  input  logic                  out_stall
);
  import rtcsm_pkg::*;

  logic       out_valid_r, out_valid_r_nxt;
  logic       skid_valid_r, skid_valid_r_nxt;
  rtcsm_out_t out_data_r, out_data_r_nxt;
  rtcsm_out_t skid_data_r, skid_data_r_nxt;
  logic       accept, out_free;

  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_res   = out_data_r;

  // Output register refills from the skid first, then from the core
  always_comb begin
    out_valid_r_nxt  = out_valid_r;
    out_data_r_nxt   = out_data_r;
    skid_valid_r_nxt = skid_valid_r;
    skid_data_r_nxt  = skid_data_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r_nxt  = 1'b1;
        out_data_r_nxt   = skid_data_r;
        skid_valid_r_nxt = 1'b0;
      end else begin
        out_valid_r_nxt = accept;
        out_data_r_nxt  = in_res;
      end
    end else if (accept) begin
      skid_valid_r_nxt = 1'b1;
      skid_data_r_nxt  = in_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_r_nxt;
      skid_valid_r <= skid_valid_r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_r_nxt;
    skid_data_r <= skid_data_r_nxt;
  end

  `ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `ASSERT_NEXT(a_held_goes_to_skid, clk, rst_n, out_valid_r && out_stall && accept,
               skid_valid_r && out_valid_r)
  `ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_valid_r && !out_stall, !skid_valid_r)

endmodule

>>> src/three_wire_rtc_serial_master.sv
// Top level of the three-wire RTC serial master.
`timescale 1ns / 1ps
// Usage:
//   Each input transaction on in_* is one tick of serial pin timing. An idle
//   master starts a single read, single write, burst read or burst write when
//   the tick carries that request; a request while busy is dropped and flagged
//   in the result's rejected bit. Every bit of a transfer spans three ticks
//   (setup with clock low, clock high, clock low), command byte first.
//   Each accepted tick gives exactly one result transaction on out_*: the pin
//   levels to apply for that tick plus busy, done and read data status.
//   Output: each result is registered into the result register or the skid.
//   Throughput: one tick per cycle while in_stall is low; the sequencer
//   update is one short combinational step into the state registers.
//   Stall: a result register plus a one-entry skid stage sit on the output, so
//   one more tick is taken while a result waits; in_stall then rises until the
//   skid stage drains.
//   Reset (rst_n low, synchronous): the master goes idle with chip enable low
//   and both result stages empty.
module three_wire_rtc_serial_master (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rtcsm_pkg::rtcsm_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rtcsm_pkg::rtcsm_out_t out_data
);
  import rtcsm_pkg::*;

  rtcsm_out_t step_res;
  logic       step_en;

  assign step_en = in_valid && !in_stall;

  // Per-tick sequencer
  rtcsm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .in_item (in_data),
    .res     (step_res)
  );

  // Result register and skid stage
  rtcsm_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_res    (step_res),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_res   (out_data),
    .out_stall (out_stall)
  );

endmodule
